[src/variable_partition_allocator_core_assert.svh]
`ifndef VARIABLE_PARTITION_ALLOCATOR_CORE_ASSERT_SVH
`define VARIABLE_PARTITION_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define VPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vpa assertion failed");

// Next-cycle implication, checked outside reset.
`define VPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vpa assertion failed");

`endif

[src/vpa_pkg.sv]
`timescale 1ns / 1ps

package vpa_pkg;

  localparam int AW = 24;
  localparam int JW = 8;

  typedef logic [AW-1:0] addr_t;
  typedef logic [JW-1:0] job_t;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RECLAIM = 2'd1;
  localparam logic [1:0] OP_INIT    = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_FIT    = 3'd1;
  localparam logic [2:0] ST_USED_FULL = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FREE_FULL = 3'd4;

  localparam logic [1:0] CFG_POOL_BASE   = 2'd0;
  localparam logic [1:0] CFG_POOL_LENGTH = 2'd1;
  localparam logic [1:0] CFG_SPLIT_THR   = 2'd2;

  localparam addr_t RST_POOL_BASE   = 24'd10240;
  localparam addr_t RST_POOL_LENGTH = 24'd10240;
  localparam addr_t RST_SPLIT_THR   = 24'd100;

  function automatic addr_t sat_add(addr_t a, addr_t b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AW] ? {AW{1'b1}} : s[AW-1:0];
  endfunction

endpackage

[src/variable_partition_allocator_core.sv]
`timescale 1ns / 1ps
// Steps: an allocate scans the free table, then commits on a fit; a reclaim scans the
// allocated table, then the free table for neighbors, then commits; init and job-zero skip scans.
// Throughput: one item at a time; the table scans read one entry per cycle from the
// free and allocated table memories, so a reclaim sets the worst case.
// Reset (rst_n low, synchronous) clears valid bits and loads the pool registers; the
// next cycle writes entry zero of the free table, then the block takes items.
module variable_partition_allocator_core #(
  parameter int FREE_ENTRIES = 16,
  parameter int USED_ENTRIES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_operation,
  input  logic [7:0]            in_job_id,
  input  logic [23:0]           in_request_length,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_status,
  output logic [23:0]           out_granted_address,
  output logic [23:0]           out_granted_length,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [23:0]           cfg_data
);

  localparam int FW   = $clog2(FREE_ENTRIES);
  localparam int UW   = $clog2(USED_ENTRIES);
  localparam int MAXE = (FREE_ENTRIES > USED_ENTRIES) ? FREE_ENTRIES : USED_ENTRIES;
  localparam int CW   = $clog2(MAXE + 1);
  localparam int AW   = vpa_pkg::AW;
  localparam int JW   = vpa_pkg::JW;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_FSCAN, S_USCAN, S_RSCAN, S_COMMIT, S_DONE
  } state_t;

  state_t state_r;

  vpa_pkg::addr_t pool_base_r, pool_len_r, thr_r;

  logic [2*AW-1:0]    free_mem [FREE_ENTRIES];
  logic [2*AW+JW-1:0] used_mem [USED_ENTRIES];
  logic [2*AW-1:0]    free_rd_r;
  logic [2*AW+JW-1:0] used_rd_r;
  logic [FREE_ENTRIES-1:0] free_valid_r;
  logic [USED_ENTRIES-1:0] used_valid_r;

  logic [1:0]      op_r;
  vpa_pkg::job_t   job_r;
  vpa_pkg::addr_t  req_r;
  logic            init_res_r;

  logic [CW-1:0]   rd_idx_r, chk_idx_r;
  logic            chk_v_r;

  // allocate: chosen free entry; reclaim: allocated entry and neighbors
  logic [FW-1:0]   k_idx_r;
  vpa_pkg::addr_t  k_start_r, k_size_r;
  logic [UW-1:0]   s_idx_r;
  vpa_pkg::addr_t  st_r, ln_r;
  logic            up_f_r, lo_f_r;
  logic [FW-1:0]   up_idx_r, lo_idx_r;
  vpa_pkg::addr_t  up_start_r, up_size_r, lo_size_r;

  logic [2:0]      res_status_r;
  vpa_pkg::addr_t  res_addr_r, res_len_r;
  logic            out_valid_r;
  logic [2:0]      out_status_r;
  vpa_pkg::addr_t  out_addr_r, out_len_r;

  logic [CW-1:0]   scan_lim;
  logic            exhausted;
  logic            u_hit;
  logic [FW-1:0]   cf;
  logic [UW-1:0]   cu;
  vpa_pkg::addr_t  rd_fstart, rd_fsize, rd_ustart, rd_usize;
  vpa_pkg::job_t   rd_owner;

  logic [FW-1:0]   inv_idx;
  logic            inv_found;
  logic [UW-1:0]   emp_idx;
  logic            emp_found;

  logic            fw_en;
  logic [FW-1:0]   fw_addr;
  logic [2*AW-1:0] fw_data;
  logic            uw_en;
  logic [UW-1:0]   uw_addr;
  logic [2*AW+JW-1:0] uw_data;
  logic            fv_clr, fv_set, uv_set, uv_clr;
  logic [FW-1:0]   fv_clr_idx, fv_set_idx;
  logic [2:0]      cm_status;
  vpa_pkg::addr_t  cm_addr, cm_len;
  vpa_pkg::addr_t  leftover;
  logic            whole, lo_eff;

  assign in_stall            = (state_r != S_IDLE);
  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_address = out_addr_r;
  assign out_granted_length  = out_len_r;

  assign scan_lim  = (state_r == S_USCAN) ? CW'(USED_ENTRIES) : CW'(FREE_ENTRIES);
  assign exhausted = !chk_v_r && (rd_idx_r == scan_lim);
  assign cf        = chk_idx_r[FW-1:0];
  assign cu        = chk_idx_r[UW-1:0];
  assign rd_fstart = free_rd_r[2*AW-1:AW];
  assign rd_fsize  = free_rd_r[AW-1:0];
  assign rd_ustart = used_rd_r[2*AW+JW-1:AW+JW];
  assign rd_usize  = used_rd_r[AW+JW-1:JW];
  assign rd_owner  = used_rd_r[JW-1:0];
  assign u_hit     = (state_r == S_USCAN) && chk_v_r && used_valid_r[cu] &&
                     (rd_owner == job_r);

  always_comb begin
    inv_idx   = '0;
    inv_found = 1'b0;
    for (int i = FREE_ENTRIES - 1; i >= 0; i--) begin
      if (!free_valid_r[i]) begin
        inv_idx   = FW'(i);
        inv_found = 1'b1;
      end
    end
  end

  always_comb begin
    emp_idx   = '0;
    emp_found = 1'b0;
    for (int i = USED_ENTRIES - 1; i >= 0; i--) begin
      if (!used_valid_r[i]) begin
        emp_idx   = UW'(i);
        emp_found = 1'b1;
      end
    end
  end

  // Table updates of a request, applied in the commit cycle, and the init write of entry zero.
  always_comb begin
    fw_en      = 1'b0;
    fw_addr    = '0;
    fw_data    = '0;
    uw_en      = 1'b0;
    uw_addr    = '0;
    uw_data    = '0;
    fv_clr     = 1'b0;
    fv_clr_idx = '0;
    fv_set     = 1'b0;
    fv_set_idx = '0;
    uv_set     = 1'b0;
    uv_clr     = 1'b0;
    cm_status  = vpa_pkg::ST_OK;
    cm_addr    = '0;
    cm_len     = '0;
    leftover   = k_size_r - req_r;
    whole      = (leftover <= thr_r);
    lo_eff     = lo_f_r && !(up_f_r && (up_idx_r == lo_idx_r));
    if (state_r == S_INIT) begin
      fw_en   = 1'b1;
      fw_data = {pool_base_r, pool_len_r};
    end else if (state_r == S_COMMIT) begin
      if (op_r == vpa_pkg::OP_ALLOC) begin
        if (!emp_found) begin
          cm_status = vpa_pkg::ST_USED_FULL;
        end else begin
          if (whole) begin
            fv_clr     = 1'b1;
            fv_clr_idx = k_idx_r;
            cm_addr    = k_start_r;
            cm_len     = k_size_r;
          end else begin
            fw_en   = 1'b1;
            fw_addr = k_idx_r;
            fw_data = {k_start_r, leftover};
            cm_addr = k_start_r + leftover;
            cm_len  = req_r;
          end
          uw_en   = 1'b1;
          uw_addr = emp_idx;
          uw_data = {cm_addr, cm_len, job_r};
          uv_set  = 1'b1;
        end
      end else begin
        cm_addr = st_r;
        cm_len  = ln_r;
        if (up_f_r && lo_eff) begin
          fw_en      = 1'b1;
          fw_addr    = up_idx_r;
          fw_data    = {up_start_r,
                        vpa_pkg::sat_add(vpa_pkg::sat_add(up_size_r, lo_size_r), ln_r)};
          fv_clr     = 1'b1;
          fv_clr_idx = lo_idx_r;
        end else if (up_f_r) begin
          fw_en   = 1'b1;
          fw_addr = up_idx_r;
          fw_data = {up_start_r, vpa_pkg::sat_add(up_size_r, ln_r)};
        end else if (lo_eff) begin
          fw_en   = 1'b1;
          fw_addr = lo_idx_r;
          fw_data = {st_r, vpa_pkg::sat_add(lo_size_r, ln_r)};
        end else if (inv_found) begin
          fw_en      = 1'b1;
          fw_addr    = inv_idx;
          fw_data    = {st_r, ln_r};
          fv_set     = 1'b1;
          fv_set_idx = inv_idx;
        end else begin
          cm_status = vpa_pkg::ST_FREE_FULL;
        end
        uv_clr = (cm_status == vpa_pkg::ST_OK);
      end
      if (cm_status != vpa_pkg::ST_OK) begin
        cm_addr = '0;
        cm_len  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fw_en) begin
      free_mem[fw_addr] <= fw_data;
    end
    if (rd_idx_r < CW'(FREE_ENTRIES)) begin
      free_rd_r <= free_mem[rd_idx_r[FW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (uw_en) begin
      used_mem[uw_addr] <= uw_data;
    end
    if (rd_idx_r < CW'(USED_ENTRIES)) begin
      used_rd_r <= used_mem[rd_idx_r[UW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      init_res_r   <= 1'b0;
      pool_base_r  <= vpa_pkg::RST_POOL_BASE;
      pool_len_r   <= vpa_pkg::RST_POOL_LENGTH;
      thr_r        <= vpa_pkg::RST_SPLIT_THR;
      free_valid_r <= '0;
      used_valid_r <= '0;
      out_valid_r  <= 1'b0;
      rd_idx_r     <= '0;
      chk_v_r      <= 1'b0;
      up_f_r       <= 1'b0;
      lo_f_r       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          vpa_pkg::CFG_POOL_BASE:   pool_base_r <= cfg_data;
          vpa_pkg::CFG_POOL_LENGTH: pool_len_r  <= cfg_data;
          vpa_pkg::CFG_SPLIT_THR:   thr_r       <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      // shared scan pipeline: address issued one cycle, entry checked the next
      if ((state_r == S_FSCAN || state_r == S_USCAN || state_r == S_RSCAN) && !u_hit) begin
        if (rd_idx_r < scan_lim) begin
          rd_idx_r  <= rd_idx_r + 1'b1;
          chk_idx_r <= rd_idx_r;
          chk_v_r   <= 1'b1;
        end else begin
          chk_v_r <= 1'b0;
        end
      end

      unique case (state_r)
        S_INIT: begin
          free_valid_r    <= FREE_ENTRIES'(1);
          used_valid_r    <= '0;
          res_status_r    <= vpa_pkg::ST_OK;
          res_addr_r      <= '0;
          res_len_r       <= '0;
          state_r         <= init_res_r ? S_DONE : S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r         <= in_operation;
            job_r        <= in_job_id;
            req_r        <= in_request_length;
            rd_idx_r     <= '0;
            chk_v_r      <= 1'b0;
            res_status_r <= vpa_pkg::ST_OK;
            res_addr_r   <= '0;
            res_len_r    <= '0;
            case (in_operation)
              vpa_pkg::OP_ALLOC, vpa_pkg::OP_RECLAIM: begin
                if (in_job_id == '0) begin
                  res_status_r <= vpa_pkg::ST_NOT_FOUND;
                  state_r      <= S_DONE;
                end else begin
                  state_r <= (in_operation == vpa_pkg::OP_ALLOC) ? S_FSCAN : S_USCAN;
                end
              end
              vpa_pkg::OP_INIT: begin
                init_res_r <= 1'b1;
                state_r    <= S_INIT;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_FSCAN: begin
          if (chk_v_r && free_valid_r[cf] && (rd_fsize >= req_r)) begin
            k_idx_r   <= cf;
            k_start_r <= rd_fstart;
            k_size_r  <= rd_fsize;
            state_r   <= S_COMMIT;
          end else if (exhausted) begin
            res_status_r <= vpa_pkg::ST_NO_FIT;
            state_r      <= S_DONE;
          end
        end
        S_USCAN: begin
          if (u_hit) begin
            s_idx_r  <= cu;
            st_r     <= rd_ustart;
            ln_r     <= rd_usize;
            up_f_r   <= 1'b0;
            lo_f_r   <= 1'b0;
            rd_idx_r <= '0;
            chk_v_r  <= 1'b0;
            state_r  <= S_RSCAN;
          end else if (exhausted) begin
            res_status_r <= vpa_pkg::ST_NOT_FOUND;
            state_r      <= S_DONE;
          end
        end
        S_RSCAN: begin
          if (chk_v_r && free_valid_r[cf] && !(up_f_r && lo_f_r)) begin
            if (({1'b0, rd_fstart} + {1'b0, rd_fsize}) == {1'b0, st_r}) begin
              up_f_r     <= 1'b1;
              up_idx_r   <= cf;
              up_start_r <= rd_fstart;
              up_size_r  <= rd_fsize;
            end
            if ({1'b0, rd_fstart} == ({1'b0, st_r} + {1'b0, ln_r})) begin
              lo_f_r    <= 1'b1;
              lo_idx_r  <= cf;
              lo_size_r <= rd_fsize;
            end
          end
          if ((up_f_r && lo_f_r) || exhausted) begin
            state_r <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (fv_clr) free_valid_r[fv_clr_idx] <= 1'b0;
          if (fv_set) free_valid_r[fv_set_idx] <= 1'b1;
          if (uv_set) used_valid_r[emp_idx] <= 1'b1;
          if (uv_clr) used_valid_r[s_idx_r] <= 1'b0;
          res_status_r <= cm_status;
          res_addr_r   <= cm_addr;
          res_len_r    <= cm_len;
          state_r      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_addr_r   <= res_addr_r;
            out_len_r    <= res_len_r;
            init_res_r   <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[src/vpa_checker.sv]
`timescale 1ns / 1ps
`include "variable_partition_allocator_core_assert.svh"

module vpa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [23:0] out_granted_address,
  input logic [23:0] out_granted_length
);

  // one item in flight: an accepted item keeps the input stalled next cycle
  `VPA_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

  `VPA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  `VPA_ASSERT_IMP(a_fail_zero, clk, rst_n,
    out_valid && (out_status != vpa_pkg::ST_OK),
    (out_granted_address == '0) && (out_granted_length == '0))

  `VPA_ASSERT_IMP(a_status_code, clk, rst_n, out_valid,
    out_status <= vpa_pkg::ST_FREE_FULL)

endmodule

bind variable_partition_allocator_core vpa_checker u_vpa_checker (.*);
